// ===== src/sqrp_pkg.sv =====
// Shared types, codes and helper functions for the server query reply parser.
// No dependencies.
`default_nettype none

package sqrp_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  field_id;
		logic [7:0]  data_byte;
		logic        field_end;
		logic [2:0]  status;
		logic        passworded;
		logic [15:0] players;
		logic [15:0] max_players;
		logic        last;
	} out_word_t;

	// results produced by one input word, in delivery order
	typedef struct packed {
		logic [1:0] count;
		out_word_t  r0;
		out_word_t  r1;
	} push_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LEN,
		PH_DATA,
		PH_TAIL,
		PH_DONE,
		PH_ERR
	} phase_t;

	typedef enum logic [2:0] {
		VS_START,
		VS_SIGNED,
		VS_INT0,
		VS_INT1,
		VS_FRAC1,
		VS_LE,
		VS_GT
	} vscan_t;

	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_HEADER  = 3'd1;
	localparam logic [2:0] ST_TRUNC_STR   = 3'd2;
	localparam logic [2:0] ST_ZERO_LEN    = 3'd3;
	localparam logic [2:0] ST_TRUNC_TAIL  = 3'd4;

	localparam logic [2:0] NUM_FIELDS     = 3'd5;
	localparam logic [2:0] VERSION_FIELD  = 3'd4;
	localparam logic [2:0] TAIL_LEN_NARROW = 3'd3;
	localparam logic [2:0] TAIL_LEN_WIDE   = 3'd5;

	// header "EYE3", index 0 is the first byte
	localparam logic [3:0][7:0] MAGIC = {8'h33, 8'h45, 8'h59, 8'h45};

	localparam int RBUF_DEPTH = 4;

	function automatic vscan_t scan_digit(input logic [7:0] c);
		vscan_t r;
		if (c == 8'h30) r = VS_INT0;
		else if (c == 8'h31) r = VS_INT1;
		else if (c >= 8'h32 && c <= 8'h39) r = VS_GT;
		else r = VS_LE;
		return r;
	endfunction

	// version text compared against 1.0, one character at a time
	function automatic vscan_t scan_next(input vscan_t st, input logic [7:0] c);
		logic   dig;
		vscan_t r;
		dig = (c >= 8'h30 && c <= 8'h39);
		case (st)
			VS_START: begin
				if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) r = VS_START;
				else if (c == 8'h2D) r = VS_LE;
				else if (c == 8'h2B) r = VS_SIGNED;
				else r = scan_digit(c);
			end
			VS_SIGNED, VS_INT0: r = scan_digit(c);
			VS_INT1: begin
				if (dig) r = VS_GT;
				else if (c == 8'h2E) r = VS_FRAC1;
				else r = VS_LE;
			end
			VS_FRAC1: begin
				if (c == 8'h30) r = VS_FRAC1;
				else if (dig) r = VS_GT;
				else r = VS_LE;
			end
			VS_GT: r = VS_GT;
			default: r = VS_LE;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/sqrp_parse.sv =====
// Parser state and per-word step logic: header check, string walk, tail counts.
// Depends on sqrp_pkg.
`default_nettype none

module sqrp_parse
	import sqrp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_word_t word,
	output push_t         push
);

	phase_t      phase_q, ph_d;
	logic [1:0]  hdr_q, hdr_d;
	logic [2:0]  fld_q, fld_d;
	logic [7:0]  left_q, left_d;
	vscan_t      vscan_q, vscan_d;
	logic [2:0]  tail_q, tail_d;
	logic        flag_q, flag_d;
	logic [15:0] pcount_q, pcount_d;
	logic [15:0] plimit_q, plimit_d;
	logic [2:0]  err_q, err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hdr_q    <= '0;
			fld_q    <= '0;
			left_q   <= '0;
			vscan_q  <= VS_START;
			tail_q   <= '0;
			flag_q   <= 1'b0;
			pcount_q <= '0;
			plimit_q <= '0;
			err_q    <= ST_OK;
		end else begin
			phase_q  <= ph_d;
			hdr_q    <= hdr_d;
			fld_q    <= fld_d;
			left_q   <= left_d;
			vscan_q  <= vscan_d;
			tail_q   <= tail_d;
			flag_q   <= flag_d;
			pcount_q <= pcount_d;
			plimit_q <= plimit_d;
			err_q    <= err_d;
		end
	end

	always_comb begin
		logic [7:0] b;
		logic       fin;
		logic [2:0] fld_inc;
		logic [2:0] tail_inc;
		logic [7:0] left_dec;
		logic       wide;
		logic [2:0] st;
		out_word_t  c;
		out_word_t  s;
		logic       cv;
		logic       sv;

		b        = word.in_byte;
		fin      = word.last_byte;
		fld_inc  = fld_q + 3'd1;
		tail_inc = tail_q + 3'd1;
		left_dec = left_q - 8'd1;
		wide     = (vscan_q == VS_GT);
		st       = ST_OK;
		c        = '0;
		s        = '0;
		cv       = 1'b0;
		sv       = 1'b0;

		ph_d     = phase_q;
		hdr_d    = hdr_q;
		fld_d    = fld_q;
		left_d   = left_q;
		vscan_d  = vscan_q;
		tail_d   = tail_q;
		flag_d   = flag_q;
		pcount_d = pcount_q;
		plimit_d = plimit_q;
		err_d    = err_q;

		if (step) begin
			case (phase_q)
				PH_HEADER: begin
					if (b != MAGIC[hdr_q]) begin
						err_d = ST_BAD_HEADER;
						ph_d  = PH_ERR;
					end else if (hdr_q == 2'd3) begin
						hdr_d = '0;
						fld_d = '0;
						ph_d  = PH_LEN;
					end else begin
						hdr_d = hdr_q + 2'd1;
					end
				end
				PH_LEN: begin
					if (b == 8'd0) begin
						err_d = ST_ZERO_LEN;
						ph_d  = PH_ERR;
					end else if (b == 8'd1) begin
						fld_d = fld_inc;
						if (fld_inc >= NUM_FIELDS) begin
							ph_d   = PH_TAIL;
							tail_d = '0;
						end else begin
							ph_d = PH_LEN;
						end
					end else begin
						left_d = b - 8'd1;
						ph_d   = PH_DATA;
					end
				end
				PH_DATA: begin
					cv          = 1'b1;
					c.kind      = KIND_DATA;
					c.field_id  = fld_q;
					c.data_byte = b;
					c.field_end = (left_q <= 8'd1);
					c.last      = !fin;
					if (fld_q == VERSION_FIELD) vscan_d = scan_next(vscan_q, b);
					left_d = left_dec;
					if (left_dec == 8'd0) begin
						fld_d = fld_inc;
						if (fld_inc >= NUM_FIELDS) begin
							ph_d   = PH_TAIL;
							tail_d = '0;
						end else begin
							ph_d = PH_LEN;
						end
					end
				end
				PH_TAIL: begin
					if (tail_q == 3'd0) begin
						flag_d = (b == 8'd1);
					end else if (!wide) begin
						if (tail_q == 3'd1) pcount_d = {8'd0, b};
						else plimit_d = {8'd0, b};
					end else begin
						case (tail_q)
							3'd1: pcount_d = {b, 8'd0};
							3'd2: pcount_d = {pcount_q[15:8], b};
							3'd3: plimit_d = {b, 8'd0};
							default: plimit_d = {plimit_q[15:8], b};
						endcase
					end
					tail_d = tail_inc;
					if (tail_inc >= (wide ? TAIL_LEN_WIDE : TAIL_LEN_NARROW)) ph_d = PH_DONE;
				end
				default: begin
				end
			endcase

			if (fin) begin
				case (ph_d)
					PH_ERR:            st = err_d;
					PH_HEADER:         st = ST_BAD_HEADER;
					PH_LEN, PH_DATA:   st = ST_TRUNC_STR;
					PH_TAIL:           st = ST_TRUNC_TAIL;
					default:           st = ST_OK;
				endcase
				sv       = 1'b1;
				s.kind   = KIND_SUMMARY;
				s.status = st;
				s.last   = 1'b1;
				if (st == ST_OK) begin
					s.passworded  = flag_d;
					s.players     = pcount_d;
					s.max_players = plimit_d;
				end
				// re-arm for the next packet
				ph_d     = PH_HEADER;
				hdr_d    = '0;
				fld_d    = '0;
				left_d   = '0;
				vscan_d  = VS_START;
				tail_d   = '0;
				flag_d   = 1'b0;
				pcount_d = '0;
				plimit_d = '0;
				err_d    = ST_OK;
			end
		end

		push.count = {1'b0, cv} + {1'b0, sv};
		push.r0    = cv ? c : s;
		push.r1    = s;
	end

endmodule

`default_nettype wire

// ===== src/sqrp_rbuf.sv =====
// Result buffer: small register FIFO taking up to two words per cycle.
// Depends on sqrp_pkg.
`default_nettype none

module sqrp_rbuf
	import sqrp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output out_word_t  out_data
);

	localparam int PW = $clog2(RBUF_DEPTH);
	localparam int CW = $clog2(RBUF_DEPTH + 1);

	out_word_t         mem_q [RBUF_DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;
	logic              pop;
	logic [PW-1:0]     wr_nxt;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign wr_nxt    = wr_q + PW'(1);
	// space for a worst-case pair of results
	assign room      = (cnt_q <= CW'(RBUF_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_q] <= push.r0;
		if (push.count == 2'd2) mem_q[wr_nxt] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push.count);
			if (pop) rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== src/server_query_reply_parser.sv =====
// Top level of the server query reply parser: input register, parser, result FIFO.
// Depends on sqrp_pkg, sqrp_parse and sqrp_rbuf.
//
// Takes one packet byte per word with a last-byte mark and returns string content
// words tagged by field plus one summary word per packet (status, password flag,
// player counts). A byte passes an input register; when the result FIFO has room,
// the parser takes it, updates its state and pushes zero, one or two result words
// into a four-entry FIFO. Sustained rate is one byte per cycle while the output
// side drains; a byte that ends a packet inside a string yields two words.
`default_nettype none

module server_query_reply_parser
	import sqrp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data
);

	logic     v_s1;
	in_word_t word_s1;
	logic     room;
	logic     advance;
	push_t    push;

	assign advance  = v_s1 && room;
	assign in_ready = !v_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) word_s1 <= in_data;
	end

	sqrp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (word_s1),
		.push   (push)
	);

	sqrp_rbuf u_rbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
